@@ rtl/dqsd_pkg.sv @@
// Package: shared types and codes for the bounded deque block.
`timescale 1ns / 1ps
package dqsd_pkg;

  localparam int VAL_W   = 32;
  localparam int CMD_W   = 3;
  localparam int CNT_OUT = 5;

  typedef logic signed [VAL_W-1:0] value_t;

  // Command codes of the input word.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DELETE     = 3'd4,
    CMD_CLEAR      = 3'd5,
    CMD_REVERSE    = 3'd6,
    CMD_SHOW       = 3'd7
  } cmd_t;

  // Status codes of the result word.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Moves broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_WR_LEN   = 3'd2,
    OP_SHL      = 3'd3,
    OP_ROT_L    = 3'd4,
    OP_ROT_R    = 3'd5
  } cell_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

@@ rtl/dqsd_if.sv @@
// Interfaces: command channel and result channel of the deque block.
`timescale 1ns / 1ps
interface dqsd_cmd_if;
  import dqsd_pkg::*;
  logic   valid;
  logic   ready;
  cmd_t   command;
  value_t item_value;

  modport source (output valid, output command, output item_value, input ready);
  modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface dqsd_res_if;
  import dqsd_pkg::*;
  logic                 valid;
  logic                 ready;
  value_t               out_value;
  status_t              status;
  logic [CNT_OUT-1:0]   entry_count;
  logic                 last_of_run;

  modport source (output valid, output out_value, output status, output entry_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_value, input status, input entry_count,
                  input last_of_run, output ready);
endinterface

@@ rtl/dqsd_cell.sv @@
// Cell: one entry of the deque chain, moved by the broadcast operation.
`timescale 1ns / 1ps
module dqsd_cell #(
  parameter int CAPACITY = 16,
  parameter int INDEX    = 0
) (
  input  logic                           clk,
  input  dqsd_pkg::cell_op_t             op,
  input  logic [$clog2(CAPACITY+1)-1:0]  len,
  input  dqsd_pkg::value_t               item_value,
  input  dqsd_pkg::value_t               left_val,
  input  dqsd_pkg::value_t               right_val,
  input  dqsd_pkg::value_t               head_val,
  input  dqsd_pkg::value_t               tail_val,
  output dqsd_pkg::value_t               value,
  output dqsd_pkg::value_t               tail_part
);
  import dqsd_pkg::*;

  localparam int CW = $clog2(CAPACITY+1);

  logic   is_last;
  logic   at_len;
  logic   below_last;
  logic   in_use;
  value_t value_next;

  // Position of this cell relative to the current fill
  assign is_last    = (len == CW'(INDEX + 1));
  assign at_len     = (len == CW'(INDEX));
  assign below_last = (len > CW'(INDEX + 1));
  assign in_use     = (len > CW'(INDEX));

  // Offer the entry to the tail select when it is the last one
  assign tail_part = is_last ? value : '0;

  // Pick the next entry from self, neighbors, ends or the input word
  always_comb begin
    value_next = value;
    case (op)
      OP_INS_HEAD: value_next = (INDEX == 0) ? item_value : left_val;
      OP_WR_LEN: begin
        if (at_len) value_next = item_value;
      end
      OP_SHL: value_next = right_val;
      OP_ROT_L: begin
        if (is_last) value_next = head_val;
        else if (below_last) value_next = right_val;
      end
      OP_ROT_R: begin
        if (INDEX == 0) value_next = tail_val;
        else if (in_use) value_next = left_val;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ rtl/bounded_deque_with_search_delete.sv @@
// Top level: bounded deque of signed words with search-and-delete, built as a chain of cells.
`timescale 1ns / 1ps
// Entries sit left-justified in a chain of CAPACITY cells; a count and a
// direction flag give the order front to back. Push, pop, clear and reverse
// each return one word. Delete-by-value and show walk the chain: every cycle
// that the result sink does not stall, the entry at the head (or tail, when
// reversed) is compared or emitted and the row rotates one place (or drops
// that entry, on the first delete match), until each entry has been visited.
// Delete drops the first matching entry while rotating, so the row comes back
// in order with the gap closed. A new command is taken once the previous one
// has finished and its last result has been accepted or is being accepted.
// The store needs no clearing after reset.
module bounded_deque_with_search_delete #(
  parameter int CAPACITY = 16
) (
  input logic         clk,
  input logic         rst,
  dqsd_cmd_if.sink    cmd_ch,
  dqsd_res_if.source  res_ch
);
  import dqsd_pkg::*;

  localparam int CW = $clog2(CAPACITY+1);
  localparam int SW = $clog2(CAPACITY);

  // Chain wiring
  value_t   vals  [CAPACITY];
  value_t   parts [CAPACITY];
  value_t   lvals [CAPACITY];
  value_t   rvals [CAPACITY];
  value_t   head;
  value_t   tail;
  cell_op_t op;

  // Control state
  state_t         state, state_next;
  logic [CW-1:0]  len, len_next;
  logic           rev, rev_next;
  logic [SW-1:0]  step, step_next;
  logic [CW-1:0]  n_q, n_next;
  logic           found, found_next;
  logic           is_show, is_show_next;
  value_t         val_q, val_next;

  // Output register
  logic               o_valid;
  value_t             o_value;
  status_t            o_status;
  logic [CNT_OUT-1:0] o_count;
  logic               o_last;

  logic    o_load;
  value_t  o_value_n;
  status_t o_status_n;
  logic    o_last_n;

  logic   load_ok;
  logic   take;
  logic   scan_adv;
  logic   scan_last;
  logic   hit;
  logic   phys_front;
  value_t cmp_val;

  // Build the cell row
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign lvals[gi] = '0;
      end else begin : g_mid
        assign lvals[gi] = vals[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_end
        assign rvals[gi] = vals[gi];
      end else begin : g_inner
        assign rvals[gi] = vals[gi+1];
      end
      dqsd_cell #(.CAPACITY(CAPACITY), .INDEX(gi)) u_cell (
        .clk        (clk),
        .op         (op),
        .len        (len),
        .item_value (cmd_ch.item_value),
        .left_val   (lvals[gi]),
        .right_val  (rvals[gi]),
        .head_val   (head),
        .tail_val   (tail),
        .value      (vals[gi]),
        .tail_part  (parts[gi])
      );
    end
  endgenerate

  // Collect the ends of the row
  assign head = vals[0];
  always_comb begin
    tail = '0;
    for (int i = 0; i < CAPACITY; i++) tail = tail | parts[i];
  end

  // Handshake
  assign load_ok      = !o_valid || res_ch.ready;
  assign cmd_ch.ready = (state == S_IDLE) && load_ok;
  assign take         = cmd_ch.valid && cmd_ch.ready;
  assign scan_adv     = (state == S_SCAN) && load_ok;
  assign scan_last    = (step == SW'(n_q - CW'(1)));
  assign cmp_val      = rev ? tail : head;
  assign hit          = !is_show && !found && (cmp_val == val_q);

  // Sequence commands and drive the row
  always_comb begin
    state_next   = state;
    len_next     = len;
    rev_next     = rev;
    step_next    = step;
    n_next       = n_q;
    found_next   = found;
    is_show_next = is_show;
    val_next     = val_q;
    op           = OP_HOLD;
    o_load       = 1'b0;
    o_value_n    = '0;
    o_status_n   = ST_OK;
    o_last_n     = 1'b1;
    phys_front   = 1'b0;
    case (state)
      S_IDLE: begin
        if (take) begin
          o_load = 1'b1;
          case (cmd_ch.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (len == CW'(CAPACITY)) begin
                o_status_n = ST_FULL;
              end else begin
                phys_front = (cmd_ch.command == CMD_PUSH_FRONT) != rev;
                op         = phys_front ? OP_INS_HEAD : OP_WR_LEN;
                len_next   = len + CW'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (len == '0) begin
                o_status_n = ST_EMPTY;
              end else begin
                phys_front = (cmd_ch.command == CMD_POP_FRONT) != rev;
                o_value_n  = phys_front ? head : tail;
                op         = phys_front ? OP_SHL : OP_HOLD;
                len_next   = len - CW'(1);
              end
            end
            CMD_DELETE, CMD_SHOW: begin
              if (len == '0) begin
                o_status_n = ST_EMPTY;
              end else begin
                o_load       = 1'b0;
                state_next   = S_SCAN;
                n_next       = len;
                step_next    = '0;
                found_next   = 1'b0;
                is_show_next = (cmd_ch.command == CMD_SHOW);
                val_next     = cmd_ch.item_value;
              end
            end
            CMD_CLEAR: begin
              len_next = '0;
              rev_next = 1'b0;
            end
            CMD_REVERSE: begin
              if (len == '0) o_status_n = ST_EMPTY;
              else rev_next = !rev;
            end
            default: o_status_n = ST_OK;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_adv) begin
          step_next = step + SW'(1);
          // Drop the first match, otherwise rotate one place
          if (hit) begin
            found_next = 1'b1;
            len_next   = len - CW'(1);
            op         = rev ? OP_HOLD : OP_SHL;
          end else begin
            op = rev ? OP_ROT_R : OP_ROT_L;
          end
          if (is_show) begin
            o_load    = 1'b1;
            o_value_n = cmp_val;
            o_last_n  = scan_last;
          end
          if (scan_last) begin
            state_next = S_IDLE;
            if (!is_show) begin
              o_load     = 1'b1;
              o_value_n  = (found || hit) ? val_q : '0;
              o_status_n = (found || hit) ? ST_OK : ST_NOTFOUND;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      len     <= '0;
      rev     <= 1'b0;
      step    <= '0;
      n_q     <= '0;
      found   <= 1'b0;
      is_show <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      len     <= len_next;
      rev     <= rev_next;
      step    <= step_next;
      n_q     <= n_next;
      found   <= found_next;
      is_show <= is_show_next;
      if (o_load) o_valid <= 1'b1;
      else if (res_ch.ready) o_valid <= 1'b0;
    end
  end

  // Hold the search value and the result word
  always_ff @(posedge clk) begin
    val_q <= val_next;
    if (o_load) begin
      o_value  <= o_value_n;
      o_status <= o_status_n;
      o_count  <= CNT_OUT'(len_next);
      o_last   <= o_last_n;
    end
  end

  assign res_ch.valid       = o_valid;
  assign res_ch.out_value   = o_value;
  assign res_ch.status      = o_status;
  assign res_ch.entry_count = o_count;
  assign res_ch.last_of_run = o_last;

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(step) < n_q))
    else $error("scan step past entry count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.status == ST_FULL) |-> (res_ch.entry_count == CNT_OUT'(CAPACITY)))
    else $error("full status without a full deque");

  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    (load_ok && o_load && !o_last_n) |-> (state == S_SCAN && is_show))
    else $error("non-final result outside a show run");

endmodule
